// File: hw/rtl/hsj_pkg.sv
// ----------------------------------------------------------------------------
// hsj_pkg
// Shared types, constants and jamo tables for the Hangul syllable splitter.
// ----------------------------------------------------------------------------
package hsj_pkg;

	localparam int MAX_BUFFER = 65536;
	localparam int CAP_W      = 17;
	localparam int COUNT_W    = 16;
	localparam int CHAR_W     = 21;

	localparam logic [CHAR_W-1:0] SYL_FIRST   = 21'h00AC00;
	localparam logic [CHAR_W-1:0] SYL_LAST    = 21'h00D7A3;
	localparam int                PER_MEDIAL  = 28;
	localparam int                PER_INITIAL = 21 * PER_MEDIAL;
	localparam logic [15:0]       EMPTY_FINAL = 16'h2592;
	localparam logic [CHAR_W-1:0] MEDIAL_BASE = 21'h00314F;

	// register indexes
	localparam logic REG_BUFFER_SIZE = 1'b0;

	// queue entry kinds
	localparam logic [1:0] KIND_END  = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_SYL  = 2'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] code;  // passed-through code point
		logic [4:0]        ini;   // initial index of a syllable
		logic [9:0]        rem;   // syllable offset within its initial block
	} entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               stopped;
	} front_stat_t;

	typedef struct packed {
		logic busy;
	} back_stat_t;

	// index of the initial block that holds s
	function automatic logic [4:0] ini_of(input logic [13:0] s);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 1; i < 19; i++) begin
			if (s >= 14'(i * PER_INITIAL))
				n = n + 5'd1;
		end
		return n;
	endfunction

	function automatic logic [4:0] med_of(input logic [9:0] r);
		logic [4:0] n;
		n = 5'd0;
		for (int j = 1; j < 21; j++) begin
			if (r >= 10'(j * PER_MEDIAL))
				n = n + 5'd1;
		end
		return n;
	endfunction

	function automatic logic [15:0] initial_jamo(input logic [4:0] i);
		logic [15:0] v;
		unique case (i)
			5'd0:  v = 16'h3131;
			5'd1:  v = 16'h3132;
			5'd2:  v = 16'h3134;
			5'd3:  v = 16'h3137;
			5'd4:  v = 16'h3138;
			5'd5:  v = 16'h3139;
			5'd6:  v = 16'h3141;
			5'd7:  v = 16'h3142;
			5'd8:  v = 16'h3143;
			5'd9:  v = 16'h3145;
			5'd10: v = 16'h3146;
			5'd11: v = 16'h3147;
			5'd12: v = 16'h3148;
			5'd13: v = 16'h3149;
			5'd14: v = 16'h314A;
			5'd15: v = 16'h314B;
			5'd16: v = 16'h314C;
			5'd17: v = 16'h314D;
			default: v = 16'h314E;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] final_jamo(input logic [4:0] f);
		logic [15:0] v;
		unique case (f)
			5'd0:  v = EMPTY_FINAL;
			5'd1:  v = 16'h3131;
			5'd2:  v = 16'h3132;
			5'd3:  v = 16'h3133;
			5'd4:  v = 16'h3134;
			5'd5:  v = 16'h3135;
			5'd6:  v = 16'h3136;
			5'd7:  v = 16'h3137;
			5'd8:  v = 16'h3139;
			5'd9:  v = 16'h313A;
			5'd10: v = 16'h313B;
			5'd11: v = 16'h313C;
			5'd12: v = 16'h313D;
			5'd13: v = 16'h313E;
			5'd14: v = 16'h313F;
			5'd15: v = 16'h3140;
			5'd16: v = 16'h3141;
			5'd17: v = 16'h3142;
			5'd18: v = 16'h3144;
			5'd19: v = 16'h3145;
			5'd20: v = 16'h3146;
			5'd21: v = 16'h3147;
			5'd22: v = 16'h3148;
			5'd23: v = 16'h314A;
			5'd24: v = 16'h314B;
			5'd25: v = 16'h314C;
			5'd26: v = 16'h314D;
			default: v = 16'h314E;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/hsj_front.sv
// ----------------------------------------------------------------------------
// hsj_front
// Accepts code points, classifies them, tracks the output count against the
// capacity and queues the items that produce results.
// ----------------------------------------------------------------------------
module hsj_front
	import hsj_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COUNT_W-1:0] limit,
	input  logic               fifo_full,
	output logic               push,
	output entry_t             push_ent,
	output front_stat_t        fst
);

	logic [COUNT_W-1:0] count_q;
	logic               stopped_q;
	logic               acc;
	logic               is_end;
	logic               is_syl;
	logic [1:0]         need;
	logic [COUNT_W:0]   next_count;
	logic               fits;
	logic [13:0]        s;
	logic [4:0]         ini;

	assign in_stall = fifo_full;
	assign acc      = in_valid && !fifo_full;
	assign is_end   = (char_code == '0);
	assign is_syl   = (char_code >= SYL_FIRST) && (char_code <= SYL_LAST);
	assign need     = is_syl ? 2'd3 : 2'd1;
	assign next_count = {1'b0, count_q} + (COUNT_W+1)'(need);
	assign fits     = next_count <= {1'b0, limit};

	assign s   = 14'(char_code - SYL_FIRST);
	assign ini = ini_of(s);

	always_comb begin
		push_ent.kind = is_end ? KIND_END : (is_syl ? KIND_SYL : KIND_CHAR);
		push_ent.code = char_code;
		push_ent.ini  = ini;
		push_ent.rem  = 10'(s - 14'(ini) * 14'(PER_INITIAL));
	end

	assign push = acc && (is_end || (!stopped_q && fits));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (acc) begin
			if (is_end) begin
				count_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (fits)
					count_q <= next_count[COUNT_W-1:0];
				else
					stopped_q <= 1'b1;
			end
		end
	end

	assign fst.count   = count_q;
	assign fst.stopped = stopped_q;

endmodule

// File: hw/rtl/hsj_fifo.sv
// ----------------------------------------------------------------------------
// hsj_fifo
// Short flop queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hsj_fifo
	import hsj_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_ent,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

endmodule

// File: hw/rtl/hsj_back.sv
// ----------------------------------------------------------------------------
// hsj_back
// Expands queued items into result characters: one for an end or a plain
// character, three jamo for a syllable, through an output register.
// ----------------------------------------------------------------------------
module hsj_back
	import hsj_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  entry_t            head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] out_char,
	output back_stat_t        bst
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_MEDIAL = 2'd1;
	localparam logic [1:0] PH_FINAL  = 2'd2;

	logic [1:0]        phase_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [9:0]        rem_q;
	logic              adv;
	logic [4:0]        med;
	logic [4:0]        fin;
	logic [CHAR_W-1:0] nxt_char;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && (phase_q == PH_IDLE) && !empty;
	assign med = med_of(rem_q);
	assign fin = 5'(rem_q - 10'(med) * 10'(PER_MEDIAL));

	always_comb begin
		nxt_char = '0;
		unique case (phase_q)
			PH_IDLE: begin
				unique case (head.kind)
					KIND_CHAR: nxt_char = head.code;
					KIND_SYL:  nxt_char = CHAR_W'(initial_jamo(head.ini));
					default:   nxt_char = '0;
				endcase
			end
			PH_MEDIAL: nxt_char = MEDIAL_BASE + CHAR_W'(med);
			PH_FINAL:  nxt_char = CHAR_W'(final_jamo(fin));
			default:   nxt_char = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			unique case (phase_q)
				PH_IDLE: begin
					out_valid_q <= !empty;
					if (!empty && head.kind == KIND_SYL)
						phase_q <= PH_MEDIAL;
				end
				PH_MEDIAL: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_FINAL;
				end
				PH_FINAL: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_IDLE;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_char_q <= nxt_char;
		if (pop)
			rem_q <= head.rem;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign bst.busy  = phase_q != PH_IDLE;

endmodule

// File: hw/rtl/hangul_syllable_to_jamo.sv
// ----------------------------------------------------------------------------
// hangul_syllable_to_jamo
// Splits precomposed Hangul syllables into compatibility jamo, passes other
// code points through, and limits each string to buffer_size-1 characters.
//
//   channel  dir  handshake            payload
//   input    in   in_valid/in_stall    char_code[20:0]
//   output   out  out_valid/out_stall  out_char[20:0]
//   config   in   APB write, pready=1  buffer_size at 0x0
//
// A plain character or end of string gives one result and a syllable three,
// emitted one per cycle by the single output register while out_stall is low.
// The front accepts one item per cycle while the four-entry queue has room.
// buffer_size saturates at 65536 and zero counts as one before the limit.
// Reset clears count, stop flag, queue and output; buffer_size resets to 4096.
// ----------------------------------------------------------------------------
module hangul_syllable_to_jamo
	import hsj_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] char_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] out_char,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CAP_W-1:0]   buffer_size_q;
	logic [CAP_W-1:0]   cap;
	logic [COUNT_W-1:0] limit;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	entry_t             push_ent;
	entry_t             head;
	front_stat_t        fst;
	back_stat_t         bst;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? 32'(buffer_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			buffer_size_q <= CAP_W'(4096);
		else if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_SIZE)
			buffer_size_q <= pwdata[CAP_W-1:0];
	end

	// saturate capacity, treat zero as one
	always_comb begin
		cap = buffer_size_q;
		if (buffer_size_q > CAP_W'(MAX_BUFFER))
			cap = CAP_W'(MAX_BUFFER);
		else if (buffer_size_q == '0)
			cap = CAP_W'(1);
		limit = COUNT_W'(cap - CAP_W'(1));
	end

	hsj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.limit     (limit),
		.fifo_full (full),
		.push      (push),
		.push_ent  (push_ent),
		.fst       (fst)
	);

	hsj_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	hsj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.bst       (bst)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_ent.kind != KIND_END) |=> (fst.count > $past(fst.count)))
		else $error("output count did not advance");

	a_stopped_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fst.stopped && push) |-> (push_ent.kind == KIND_END))
		else $error("item queued while stopped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !bst.busy && !out_stall) |=> !out_valid)
		else $error("result without queued item");
`endif

endmodule

// File: tb/jamo_checker.sv
// ----------------------------------------------------------------------------
// jamo_checker
// Watches the item and result channels of hangul_syllable_to_jamo. Every
// accepted code point is split into the jamo it should produce, and every
// accepted output character is matched against the oldest one still due.
// Capacity writes on the APB port are tracked so the per-string limit is known.
// ----------------------------------------------------------------------------
module jamo_checker
	import hsj_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [CHAR_W-1:0] out_char,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CAP_ADDR = {REG_BUFFER_SIZE, 2'b00};

	// initial consonants, index 0 in the top slot
	localparam logic [19*16-1:0] LEAD_JAMO = {
		16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
		16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
		16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
	};

	// final consonants, slot 0 is the filler for a syllable with no final
	localparam logic [28*16-1:0] TAIL_JAMO = {
		EMPTY_FINAL, 16'h3131, 16'h3132, 16'h3133, 16'h3134, 16'h3135, 16'h3136,
		16'h3137, 16'h3139, 16'h313A, 16'h313B, 16'h313C, 16'h313D, 16'h313E,
		16'h313F, 16'h3140, 16'h3141, 16'h3142, 16'h3144, 16'h3145, 16'h3146,
		16'h3147, 16'h3148, 16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E
	};

	logic [CAP_W-1:0]   cap_reg;
	logic [COUNT_W-1:0] char_count;
	logic               halted;
	logic [CHAR_W-1:0]  jamo_due[$];
	logic [CHAR_W-1:0]  due;

	task automatic split_item(input logic [CHAR_W-1:0] c);
		int unsigned lim;
		int unsigned s;
		int unsigned lead;
		int unsigned vowel;
		int unsigned tail;
		lim = cap_reg;
		if (lim > MAX_BUFFER)
			lim = MAX_BUFFER;
		if (lim == 0)
			lim = 1;
		lim = lim - 1;
		if (c == '0) begin
			// end of string: terminator always comes out, then start over
			jamo_due.push_back('0);
			char_count = '0;
			halted = 1'b0;
		end else if (!halted && c >= SYL_FIRST && c <= SYL_LAST) begin
			if (char_count + 3 > lim) begin
				halted = 1'b1;
			end else begin
				s = c - SYL_FIRST;
				lead = s / PER_INITIAL;
				vowel = (s % PER_INITIAL) / PER_MEDIAL;
				tail = s % PER_MEDIAL;
				jamo_due.push_back(CHAR_W'(LEAD_JAMO[(18 - lead) * 16 +: 16]));
				jamo_due.push_back(MEDIAL_BASE + CHAR_W'(vowel));
				jamo_due.push_back(CHAR_W'(TAIL_JAMO[(27 - tail) * 16 +: 16]));
				char_count = char_count + COUNT_W'(3);
			end
		end else if (!halted) begin
			if (char_count + 1 > lim) begin
				halted = 1'b1;
			end else begin
				jamo_due.push_back(c);
				char_count = char_count + COUNT_W'(1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg = CAP_W'(4096);
			char_count = '0;
			halted = 1'b0;
			jamo_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			// an item taken at the same edge as a write still sees the old capacity
			if (in_valid && !in_stall)
				split_item(char_code);
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				cap_reg = pwdata[CAP_W-1:0];
			if (out_valid && !out_stall) begin
				if (jamo_due.size() == 0) begin
					errors++;
					$display("%0t: out_char expected nothing, got %h", $time, out_char);
				end else begin
					due = jamo_due.pop_front();
					if (out_char !== due) begin
						errors++;
						$display("%0t: out_char expected %h, got %h", $time, due, out_char);
					end
				end
			end
			pending = jamo_due.size();
		end
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives hangul_syllable_to_jamo with directed and random strings of code
// points under several buffer capacities, with bursty input, a stalling
// output side and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
	import hsj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CHAR_W-1:0] char_code;
	logic              out_valid;
	logic              out_stall;
	logic [CHAR_W-1:0] out_char;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                burst_left;
	bit                long_hold_req;

	always #1 clk = ~clk;

	hangul_syllable_to_jamo i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	jamo_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.errors    (errors),
		.pending   (pending)
	);

	// hand one item over, then maybe pause before the next burst
	task automatic offer(input logic [CHAR_W-1:0] code);
		int gap;
		char_code <= code;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and let every due character and any silent queued item drain
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_BUFFER_SIZE, 2'b00};
		pwdata <= 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] rand_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 55)
			return CHAR_W'($urandom_range(SYL_FIRST, SYL_LAST));
		else if (r < 65)
			return CHAR_W'($urandom_range(1, 127));
		else if (r < 70)
			case ($urandom_range(0, 3))
				0: return CHAR_W'(SYL_FIRST - 1);
				1: return CHAR_W'(SYL_LAST + 1);
				2: return CHAR_W'($urandom_range(21'h00D800, 21'h00DFFF));
				default: return 21'h1FFFFF;
			endcase
		else
			return CHAR_W'($urandom_range(1, 21'h1FFFFF));
	endfunction

	// output side: stall patterns of random mode and length, one long hold-off
	initial begin
		int mode;
		int left;
		int hold;
		bit held;
		out_stall = 1'b0;
		mode = 0;
		left = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !held) begin
				hold = 150;
				held = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(4, 40);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		#200000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [CAP_W-1:0] caps[12];
		int items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst_left = 0;
		long_hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: syllable bounds, top initial, out-of-range and surrogates
		offer(21'h00AC00); offer(21'h00D7A3); offer(21'h00AC01); offer(21'h00D558);
		offer(21'h000041); offer(21'h1FFFFF); offer(21'h10FFFF); offer(21'h00D800);
		offer(21'h00ABFF); offer(21'h00D7A4); offer(21'h000001); offer(21'h000000);

		// exactly room for one syllable, then a character that no longer fits
		set_capacity(4);
		offer(21'h00AC00); offer(21'h000041); offer(21'h000042); offer(21'h000000);

		// syllable too big for what is left stops even a fitting character
		set_capacity(5);
		offer(21'h000041); offer(21'h000041); offer(21'h00AC00); offer(21'h000042);
		offer(21'h000000);

		// no room at all
		set_capacity(1);
		offer(21'h000041); offer(21'h00AC00); offer(21'h000000);
		set_capacity(0);
		offer(21'h000041); offer(21'h000000);

		caps = '{2, 1, 131071, 7, 65536, 0, 10, 65535,
			$urandom_range(1, 40), $urandom_range(1, 40), 4, 30};
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			if (p == 2) begin
				// keep offering while the output holds off
				long_hold_req = 1'b1;
				burst_left = 40;
			end
			for (items = 0; items < 27; items++)
				offer(rand_code());
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: hangul_syllable_to_jamo.f
hw/rtl/hsj_pkg.sv
hw/rtl/hsj_front.sv
hw/rtl/hsj_fifo.sv
hw/rtl/hsj_back.sv
hw/rtl/hangul_syllable_to_jamo.sv
tb/jamo_checker.sv
tb/tb.sv
